// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the Otsu binarizer.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/otsu_pkg.sv -----
// Types and constants of the Otsu threshold binarizer.
// Used by otsu_mul and otsu_threshold_binarizer; depends on nothing.
`default_nettype none
package otsu_pkg;

  localparam int COUNT_BITS = 20;
  localparam int CW   = COUNT_BITS;
  localparam int SW   = CW + 16;
  localparam int WBW  = CW + 8;
  localparam int DW   = CW + SW;
  localparam int NW   = 2 * DW;
  localparam int DNW  = 2 * CW;
  localparam int AW   = NW;
  localparam int BW   = DW;
  localparam int PW   = AW + BW;
  localparam int BINS = 256;

  localparam logic [CW-1:0] CountCap = {CW{1'b1}};
  localparam logic [7:0]    LastBin  = 8'd255;
  localparam logic [7:0]    PixHigh  = 8'd255;
  localparam logic [7:0]    PixLow   = 8'd0;

  localparam logic OpAccum    = 1'b0;
  localparam logic OpClassify = 1'b1;
  localparam logic KindThr    = 1'b0;
  localparam logic KindPixel  = 1'b1;

  typedef enum logic [3:0] {
    StIdle, StWait, StRead, StBin, StMulP, StMulQ, StMulNum, StMulDen,
    StMulL, StMulR, StNext, StOut, StClear
  } otsu_state_e;

endpackage
`default_nettype wire

// ----- sv/otsu_threshold_binarizer.sv -----
// Top level of the Otsu threshold binarizer: histogram memory, scan sequencer, output word.
// Depends on otsu_pkg, otsu_mul and assert_macros.svh.
`default_nettype none
// Accumulate and classify words are taken one per cycle. After reset the block clears
// all 256 bins of the histogram, a single-port-write, registered-read memory, and
// takes no word meanwhile. The word marked last in accumulate mode starts a scan of the
// 256 bins; every bin is read and cleared once. Bins up to the one where the running
// count reaches the pixel total pass through the read, bin and next states, the rest
// through the read state alone, and each bin whose running count lies above zero and
// below the pixel total adds six products on the bit-serial multiplier.
// No input word is taken during the scan, nor while a result waits at the output and
// is not being taken.
module otsu_threshold_binarizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // pixel
  input  logic       s_axis_tuser,   // opcode
  input  logic       s_axis_tlast,   // last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // value
  output logic       m_axis_tuser    // kind
);

  localparam int CW  = otsu_pkg::CW;
  localparam int SW  = otsu_pkg::SW;
  localparam int WBW = otsu_pkg::WBW;
  localparam int DW  = otsu_pkg::DW;
  localparam int NW  = otsu_pkg::NW;
  localparam int DNW = otsu_pkg::DNW;
  localparam int AW  = otsu_pkg::AW;
  localparam int BW  = otsu_pkg::BW;
  localparam int PW  = otsu_pkg::PW;

  otsu_pkg::otsu_state_e state_q, state_d;

  logic [CW-1:0]  hist_mem [otsu_pkg::BINS];
  logic [CW-1:0]  rd_q;
  logic           s1_vld_q;
  logic [7:0]     s1_pix_q;
  logic           fwd_q;
  logic [CW-1:0]  fwd_val_q;

  logic [7:0]     t_q, t_d;
  logic           stop_q, stop_d;
  logic           run_q, run_d;
  logic [WBW-1:0] wb_q, wb_d;
  logic [SW-1:0]  sumb_q, sumb_d;
  logic [DW-1:0]  p_q, p_d;
  logic [DW-1:0]  d_q, d_d;
  logic [NW-1:0]  num_q, num_d;
  logic [DNW-1:0] den_q, den_d;
  logic [PW-1:0]  lhs_q, lhs_d;
  logic [NW-1:0]  bnum_q, bnum_d;
  logic [DNW-1:0] bden_q, bden_d;
  logic [7:0]     thr_q, thr_d;
  logic [CW-1:0]  n_q, n_d;
  logic [SW-1:0]  s_q, s_d;

  logic           out_vld_q;
  logic           out_kind_q;
  logic [7:0]     out_val_q;

  logic           in_acc, acc_take, out_free, load_cls, load_thr;
  logic [CW-1:0]  h_cur, h_new;
  logic           h_inc;
  logic           wen;
  logic [7:0]     waddr, raddr;
  logic [CW-1:0]  wdata;
  logic [WBW-1:0] wb_next;
  logic           bin_skip;
  logic [DW-1:0]  q_val;
  logic           mul_start, mul_done;
  logic [AW-1:0]  mul_a;
  logic [BW-1:0]  mul_b;
  logic [PW-1:0]  mul_p;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign s_axis_tready = (state_q == otsu_pkg::StIdle) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign acc_take      = in_acc && (s_axis_tuser == otsu_pkg::OpAccum);
  assign load_cls      = in_acc && (s_axis_tuser == otsu_pkg::OpClassify);
  assign load_thr      = (state_q == otsu_pkg::StOut) && out_free;

  assign h_cur = fwd_q ? fwd_val_q : rd_q;
  assign h_inc = (h_cur != otsu_pkg::CountCap);
  assign h_new = h_cur + CW'(h_inc);

  assign wen   = s1_vld_q || (state_q == otsu_pkg::StRead) || (state_q == otsu_pkg::StClear);
  assign waddr = s1_vld_q ? s1_pix_q : t_q;
  assign wdata = s1_vld_q ? h_new : '0;
  assign raddr = (state_q == otsu_pkg::StRead) ? t_q : s_axis_tdata;

  always_ff @(posedge clk_i) begin
    if (wen) begin
      hist_mem[waddr] <= wdata;
    end
    rd_q      <= hist_mem[raddr];
    fwd_q     <= s1_vld_q && (s1_pix_q == s_axis_tdata);
    fwd_val_q <= h_new;
    s1_pix_q  <= s_axis_tdata;
  end

  assign wb_next  = wb_q + WBW'(rd_q);
  assign bin_skip = (wb_next == '0) || (wb_next >= WBW'(n_q));
  assign q_val    = mul_p[DW-1:0];

  otsu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_p)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      otsu_pkg::StClear: begin
        if (t_q == otsu_pkg::LastBin) state_d = otsu_pkg::StIdle;
      end
      otsu_pkg::StIdle: begin
        if (acc_take && s_axis_tlast) state_d = otsu_pkg::StWait;
      end
      otsu_pkg::StWait:   state_d = otsu_pkg::StRead;
      otsu_pkg::StRead: begin
        if (!stop_q) begin
          state_d = otsu_pkg::StBin;
        end else if (t_q == otsu_pkg::LastBin) begin
          state_d = otsu_pkg::StOut;
        end
      end
      otsu_pkg::StBin:    state_d = bin_skip ? otsu_pkg::StNext : otsu_pkg::StMulP;
      otsu_pkg::StMulP:   if (mul_done) state_d = otsu_pkg::StMulQ;
      otsu_pkg::StMulQ:   if (mul_done) state_d = otsu_pkg::StMulNum;
      otsu_pkg::StMulNum: if (mul_done) state_d = otsu_pkg::StMulDen;
      otsu_pkg::StMulDen: if (mul_done) state_d = otsu_pkg::StMulL;
      otsu_pkg::StMulL:   if (mul_done) state_d = otsu_pkg::StMulR;
      otsu_pkg::StMulR:   if (mul_done) state_d = otsu_pkg::StNext;
      otsu_pkg::StNext: begin
        state_d = (t_q == otsu_pkg::LastBin) ? otsu_pkg::StOut : otsu_pkg::StRead;
      end
      otsu_pkg::StOut:    if (out_free) state_d = otsu_pkg::StIdle;
      default:            state_d = otsu_pkg::StIdle;
    endcase
  end

  always_comb begin
    t_d = t_q;  stop_d = stop_q;  wb_d = wb_q;  sumb_d = sumb_q;
    p_d = p_q;  d_d = d_q;  num_d = num_q;  den_d = den_q;  lhs_d = lhs_q;
    bnum_d = bnum_q;  bden_d = bden_q;  thr_d = thr_q;  n_d = n_q;  s_d = s_q;
    mul_a = '0;  mul_b = '0;
    case (state_q)
      otsu_pkg::StClear: begin
        if (t_q != otsu_pkg::LastBin) t_d = t_q + 8'd1;
      end
      otsu_pkg::StWait: begin
        t_d = '0;  stop_d = 1'b0;  wb_d = '0;  sumb_d = '0;
        bnum_d = '0;  bden_d = DNW'(1);  thr_d = '0;
      end
      otsu_pkg::StRead: begin
        if (stop_q && (t_q != otsu_pkg::LastBin)) t_d = t_q + 8'd1;
      end
      otsu_pkg::StBin: begin
        wb_d = wb_next;
        if (wb_next != '0 && wb_next >= WBW'(n_q)) begin
          stop_d = 1'b1;
        end else if (!bin_skip) begin
          sumb_d = sumb_q + SW'(t_q) * SW'(rd_q);
        end
      end
      otsu_pkg::StMulP: begin
        mul_a = AW'(sumb_q);
        mul_b = BW'(n_q);
        if (mul_done) p_d = mul_p[DW-1:0];
      end
      otsu_pkg::StMulQ: begin
        mul_a = AW'(s_q);
        mul_b = BW'(wb_q);
        if (mul_done) d_d = (p_q >= q_val) ? (p_q - q_val) : (q_val - p_q);
      end
      otsu_pkg::StMulNum: begin
        mul_a = AW'(d_q);
        mul_b = d_q;
        if (mul_done) num_d = mul_p[NW-1:0];
      end
      otsu_pkg::StMulDen: begin
        mul_a = AW'(wb_q[CW-1:0]);
        mul_b = BW'(n_q - wb_q[CW-1:0]);
        if (mul_done) den_d = mul_p[DNW-1:0];
      end
      otsu_pkg::StMulL: begin
        mul_a = num_q;
        mul_b = BW'(bden_q);
        if (mul_done) lhs_d = mul_p;
      end
      otsu_pkg::StMulR: begin
        mul_a = bnum_q;
        mul_b = BW'(den_q);
        if (mul_done && (lhs_q > mul_p)) begin
          bnum_d = num_q;
          bden_d = den_q;
          thr_d  = t_q;
        end
      end
      otsu_pkg::StNext: begin
        if (t_q != otsu_pkg::LastBin) t_d = t_q + 8'd1;
      end
      otsu_pkg::StOut: begin
        if (out_free) begin
          n_d = '0;
          s_d = '0;
        end
      end
      default: begin
      end
    endcase
    if (s1_vld_q) begin
      if (n_q != otsu_pkg::CountCap) n_d = n_q + CW'(1);
      if (h_inc) s_d = s_q + SW'(s1_pix_q);
    end
  end

  always_comb begin
    mul_start = 1'b0;
    case (state_q)
      otsu_pkg::StMulP, otsu_pkg::StMulQ, otsu_pkg::StMulNum,
      otsu_pkg::StMulDen, otsu_pkg::StMulL, otsu_pkg::StMulR: begin
        mul_start = !run_q;
      end
      default: mul_start = 1'b0;
    endcase
  end

  always_comb begin
    if (mul_start) begin
      run_d = 1'b1;
    end else if (mul_done) begin
      run_d = 1'b0;
    end else begin
      run_d = run_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= otsu_pkg::StClear;
      s1_vld_q   <= 1'b0;
      run_q      <= 1'b0;
      stop_q     <= 1'b0;
      t_q        <= '0;
      wb_q       <= '0;
      thr_q      <= '0;
      n_q        <= '0;
      s_q        <= '0;
      out_vld_q  <= 1'b0;
      out_kind_q <= otsu_pkg::KindThr;
      out_val_q  <= '0;
    end else begin
      state_q  <= state_d;
      s1_vld_q <= acc_take;
      run_q    <= run_d;
      stop_q   <= stop_d;
      t_q      <= t_d;
      wb_q     <= wb_d;
      thr_q    <= thr_d;
      n_q      <= n_d;
      s_q      <= s_d;
      if (load_cls) begin
        out_vld_q  <= 1'b1;
        out_kind_q <= otsu_pkg::KindPixel;
        out_val_q  <= (s_axis_tdata >= thr_q) ? otsu_pkg::PixHigh : otsu_pkg::PixLow;
      end else if (load_thr) begin
        out_vld_q  <= 1'b1;
        out_kind_q <= otsu_pkg::KindThr;
        out_val_q  <= thr_q;
      end else if (m_axis_tready) begin
        out_vld_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sumb_q <= sumb_d;
    p_q    <= p_d;
    d_q    <= d_d;
    num_q  <= num_d;
    den_q  <= den_d;
    lhs_q  <= lhs_d;
    bnum_q <= bnum_d;
    bden_q <= bden_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_val_q;
  assign m_axis_tuser  = out_kind_q;

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_scan_after_drain, (state_q == otsu_pkg::StRead) |-> !s1_vld_q, "scan read while a bin update is pending")
  `ASSERT_NEXT(a_classify_result, load_cls, m_axis_tvalid && (m_axis_tuser == otsu_pkg::KindPixel), "classify word gave no pixel result")
  `ASSERT_ALWAYS(a_stop_past_total, (stop_q && (state_q == otsu_pkg::StRead)) |-> (wb_q >= WBW'(n_q)), "scan stopped before the bin sum reached the pixel count")
  `ASSERT_NEXT(a_threshold_result, load_thr, m_axis_tvalid && (m_axis_tuser == otsu_pkg::KindThr), "scan end gave no threshold result")

endmodule
`default_nettype wire

// ----- sv/otsu_mul.sv -----
// Bit-serial shift-and-add multiplier used by the threshold scan.
// Depends on otsu_pkg for the operand and product widths.
`default_nettype none
module otsu_mul (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [otsu_pkg::AW-1:0]  a_i,
  input  logic [otsu_pkg::BW-1:0]  b_i,
  output logic                     done_o,
  output logic [otsu_pkg::PW-1:0]  prod_o
);

  logic                    busy_q, busy_d;
  logic                    done_q, done_d;
  logic [otsu_pkg::PW-1:0] acc_q, acc_d;
  logic [otsu_pkg::PW-1:0] ash_q, ash_d;
  logic [otsu_pkg::BW-1:0] bsh_q, bsh_d;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    ash_d  = ash_q;
    bsh_d  = bsh_q;
    if (start_i) begin
      busy_d = 1'b1;
      acc_d  = '0;
      ash_d  = otsu_pkg::PW'(a_i);
      bsh_d  = b_i;
    end else if (busy_q) begin
      if (bsh_q[0]) begin
        acc_d = acc_q + ash_q;
      end
      ash_d = ash_q << 1;
      bsh_d = bsh_q >> 1;
      if ((bsh_q >> 1) == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    ash_q <= ash_d;
    bsh_q <= bsh_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule
`default_nettype wire
